FILE: src/u8d_pkg.sv
// ============================================================================
// u8d_pkg
// Shared types and constants of the UTF-8 stream decoder: the result word, the
// group of results that the decoder pushes for one input byte, and the sizes
// of the result queue.
// ============================================================================

package u8d_pkg;

    localparam int CODE_W     = 21;
    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 3;
    localparam int SEEN_W     = 2;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [CODE_W-1:0] REPL_RESET   = 21'h00FFFD;
    localparam logic [CODE_W-1:0] MAX_SCALAR   = 21'h10FFFF;
    localparam logic [CODE_W-1:0] SURR_LOW     = 21'h00D800;
    localparam logic [CODE_W-1:0] SURR_HIGH    = 21'h00DFFF;
    localparam logic [CODE_W-1:0] MIN_SCALAR_2 = 21'h000080;
    localparam logic [CODE_W-1:0] MIN_SCALAR_3 = 21'h000800;
    localparam logic [CODE_W-1:0] MIN_SCALAR_4 = 21'h010000;

    localparam logic [LEN_W-1:0] SEQ_NONE = 3'd0;
    localparam logic [LEN_W-1:0] SEQ_LEN2 = 3'd2;
    localparam logic [LEN_W-1:0] SEQ_LEN3 = 3'd3;
    localparam logic [LEN_W-1:0] SEQ_LEN4 = 3'd4;

    typedef struct packed {
        logic [CODE_W-1:0] code_point;
        logic              is_replacement;
        logic              last_of_run;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } dec_push_t;

endpackage

FILE: src/utf8_stream_decoder.sv
// ============================================================================
// utf8_stream_decoder
// UTF-8 decoder with replacement of malformed input, one byte per word.
// ============================================================================
// The block takes one byte per cycle unless byte_stall is high and gives one
// result word per cycle unless result_stall is high. A byte enters an input
// register and is decoded from it into zero, one or two results, which wait in
// a four-word result queue; the decoder stalls the input only while that queue
// holds more than two words, so a byte that yields one result passes at full
// rate. The result queue is registered, and its head word is presented on the
// output. The replacement code register resets to U+FFFD and is written
// through cfg_write and cfg_data.

module utf8_stream_decoder (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [u8d_pkg::CODE_W-1:0]    cfg_data,
    input  logic                          byte_valid,
    output logic                          byte_stall,
    input  logic [u8d_pkg::BYTE_W-1:0]    data_byte,
    input  logic                          end_of_input,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [u8d_pkg::CODE_W-1:0]    code_point,
    output logic                          is_replacement,
    output logic                          last_of_run
);

    logic [u8d_pkg::CODE_W-1:0]    repl_code_reg;
    u8d_pkg::dec_push_t            push;
    u8d_pkg::result_t              head;
    logic                          queue_room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            repl_code_reg <= u8d_pkg::REPL_RESET;
        else if (cfg_write)
            repl_code_reg <= cfg_data;
    end

    u8d_decode u_decode (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .data_byte    (data_byte),
        .end_of_input (end_of_input),
        .repl_code    (repl_code_reg),
        .queue_room   (queue_room),
        .push         (push)
    );

    u8d_result_fifo u_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .room         (queue_room),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .head         (head)
    );

    assign code_point     = head.code_point;
    assign is_replacement = head.is_replacement;
    assign last_of_run    = head.last_of_run;

endmodule

FILE: src/u8d_decode.sv
// ============================================================================
// u8d_decode
// Input register and decoder state. Each registered byte is decoded into
// zero, one or two results, which are pushed into the result queue when the
// queue has room for two.
// ============================================================================

module u8d_decode (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          byte_valid,
    output logic                          byte_stall,
    input  logic [u8d_pkg::BYTE_W-1:0]    data_byte,
    input  logic                          end_of_input,
    input  logic [u8d_pkg::CODE_W-1:0]    repl_code,
    input  logic                          queue_room,
    output u8d_pkg::dec_push_t            push
);

    typedef struct packed {
        logic                         emit;
        u8d_pkg::result_t             res;
        logic [u8d_pkg::LEN_W-1:0]    len;
        logic [u8d_pkg::CODE_W-1:0]   partial;
    } lead_t;

    logic                          in_valid_reg;
    logic [u8d_pkg::BYTE_W-1:0]    byte_reg;
    logic                          eoi_reg;
    logic [u8d_pkg::LEN_W-1:0]     exp_len_reg;
    logic [u8d_pkg::LEN_W-1:0]     exp_len_next;
    logic [u8d_pkg::SEEN_W-1:0]    seen_reg;
    logic [u8d_pkg::SEEN_W-1:0]    seen_next;
    logic [u8d_pkg::CODE_W-1:0]    partial_reg;
    logic [u8d_pkg::CODE_W-1:0]    partial_next;
    logic                          consume;
    logic                          accept;
    lead_t                         lead;
    logic [u8d_pkg::LEN_W-1:0]     seen_inc;
    logic [u8d_pkg::CODE_W-1:0]    partial_cont;
    logic                          legal;
    u8d_pkg::result_t              repl_res;

    function automatic lead_t lead_decode(
        input logic [u8d_pkg::BYTE_W-1:0]  b,
        input logic                        last,
        input logic [u8d_pkg::CODE_W-1:0]  repl
    );
        lead_t s;
        s.emit               = 1'b0;
        s.res.code_point     = repl;
        s.res.is_replacement = 1'b1;
        s.res.last_of_run    = 1'b1;
        s.len                = u8d_pkg::SEQ_NONE;
        s.partial            = '0;
        if (b[7] == 1'b0)
        begin
            s.emit               = 1'b1;
            s.res.code_point     = {13'd0, b};
            s.res.is_replacement = 1'b0;
        end
        else if (b[7:5] == 3'b110)
        begin
            s.len     = u8d_pkg::SEQ_LEN2;
            s.partial = {16'd0, b[4:0]};
        end
        else if (b[7:4] == 4'b1110)
        begin
            s.len     = u8d_pkg::SEQ_LEN3;
            s.partial = {17'd0, b[3:0]};
        end
        else if (b[7:3] == 5'b11110)
        begin
            s.len     = u8d_pkg::SEQ_LEN4;
            s.partial = {18'd0, b[2:0]};
        end
        else
        begin
            s.emit = 1'b1;
        end
        if ((s.len != u8d_pkg::SEQ_NONE) && last)
        begin
            s.emit    = 1'b1;
            s.len     = u8d_pkg::SEQ_NONE;
            s.partial = '0;
        end
        return s;
    endfunction

    assign consume    = in_valid_reg && queue_room;
    assign byte_stall = in_valid_reg && !queue_room;
    assign accept     = byte_valid && !byte_stall;

    assign lead         = lead_decode(byte_reg, eoi_reg, repl_code);
    assign seen_inc     = {1'b0, seen_reg} + 3'd1;
    assign partial_cont = {partial_reg[14:0], byte_reg[5:0]};

    assign repl_res.code_point     = repl_code;
    assign repl_res.is_replacement = 1'b1;
    assign repl_res.last_of_run    = 1'b1;

    always_comb
    begin
        legal = 1'b1;
        if (partial_cont > u8d_pkg::MAX_SCALAR)
            legal = 1'b0;
        if ((partial_cont >= u8d_pkg::SURR_LOW) && (partial_cont <= u8d_pkg::SURR_HIGH))
            legal = 1'b0;
        if ((exp_len_reg == u8d_pkg::SEQ_LEN2) && (partial_cont < u8d_pkg::MIN_SCALAR_2))
            legal = 1'b0;
        if ((exp_len_reg == u8d_pkg::SEQ_LEN3) && (partial_cont < u8d_pkg::MIN_SCALAR_3))
            legal = 1'b0;
        if ((exp_len_reg == u8d_pkg::SEQ_LEN4) && (partial_cont < u8d_pkg::MIN_SCALAR_4))
            legal = 1'b0;
    end

    always_comb
    begin
        exp_len_next = exp_len_reg;
        seen_next    = seen_reg;
        partial_next = partial_reg;
        push.count   = 2'd0;
        push.first   = repl_res;
        push.second  = repl_res;
        if (consume)
        begin
            if (exp_len_reg != u8d_pkg::SEQ_NONE)
            begin
                if (byte_reg[7:6] == 2'b10)
                begin
                    if (seen_inc >= exp_len_reg)
                    begin
                        push.count = 2'd1;
                        if (legal)
                        begin
                            push.first.code_point     = partial_cont;
                            push.first.is_replacement = 1'b0;
                        end
                        exp_len_next = u8d_pkg::SEQ_NONE;
                        seen_next    = '0;
                        partial_next = '0;
                    end
                    else if (eoi_reg)
                    begin
                        push.count   = 2'd1;
                        exp_len_next = u8d_pkg::SEQ_NONE;
                        seen_next    = '0;
                        partial_next = '0;
                    end
                    else
                    begin
                        seen_next    = seen_inc[u8d_pkg::SEEN_W-1:0];
                        partial_next = partial_cont;
                    end
                end
                else
                begin
                    push.count   = 2'd1;
                    exp_len_next = lead.len;
                    seen_next    = (lead.len != u8d_pkg::SEQ_NONE) ? 2'd1 : 2'd0;
                    partial_next = lead.partial;
                    if (lead.emit)
                    begin
                        push.count             = 2'd2;
                        push.first.last_of_run = 1'b0;
                        push.second            = lead.res;
                    end
                end
            end
            else
            begin
                exp_len_next = lead.len;
                seen_next    = (lead.len != u8d_pkg::SEQ_NONE) ? 2'd1 : 2'd0;
                partial_next = lead.partial;
                if (lead.emit)
                begin
                    push.count = 2'd1;
                    push.first = lead.res;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            exp_len_reg  <= u8d_pkg::SEQ_NONE;
            seen_reg     <= '0;
            partial_reg  <= '0;
        end
        else
        begin
            if (accept)
                in_valid_reg <= 1'b1;
            else if (consume)
                in_valid_reg <= 1'b0;
            exp_len_reg <= exp_len_next;
            seen_reg    <= seen_next;
            partial_reg <= partial_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= data_byte;
            eoi_reg  <= end_of_input;
        end
    end

`ifndef ASSERT_OFF
    a_idle_seen_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (exp_len_reg == u8d_pkg::SEQ_NONE) |-> (seen_reg == 2'd0))
        else $error("Byte count held with no sequence pending.");

    a_pending_in_range : assert property (@(posedge clk) disable iff (!rst_n)
        (exp_len_reg != u8d_pkg::SEQ_NONE) |->
            ((seen_reg != 2'd0) && ({1'b0, seen_reg} < exp_len_reg)))
        else $error("Pending sequence has an impossible byte count.");

    a_second_needs_break : assert property (@(posedge clk) disable iff (!rst_n)
        (push.count == 2'd2) |->
            (($past(exp_len_next) == exp_len_reg) && push.first.is_replacement))
        else $error("Two results pushed without a broken sequence.");
`endif

endmodule

FILE: src/u8d_result_fifo.sv
// ============================================================================
// u8d_result_fifo
// Small result queue. It takes up to two results a cycle from the decoder and
// hands out one word a cycle on the output channel while result_stall is low.
// ============================================================================

module u8d_result_fifo (
    input  logic                                clk,
    input  logic                                rst_n,
    input  u8d_pkg::dec_push_t                  push,
    output logic                                room,
    output logic                                result_valid,
    input  logic                                result_stall,
    output u8d_pkg::result_t                    head
);

    u8d_pkg::result_t                  mem [u8d_pkg::FIFO_DEPTH];
    logic [u8d_pkg::FIFO_PTR_W-1:0]    wr_ptr_reg;
    logic [u8d_pkg::FIFO_PTR_W-1:0]    wr_ptr_next;
    logic [u8d_pkg::FIFO_PTR_W-1:0]    wr_ptr_plus1;
    logic [u8d_pkg::FIFO_PTR_W-1:0]    rd_ptr_reg;
    logic [u8d_pkg::FIFO_PTR_W-1:0]    rd_ptr_next;
    logic [u8d_pkg::FIFO_CNT_W-1:0]    count_reg;
    logic [u8d_pkg::FIFO_CNT_W-1:0]    count_next;
    logic                              pop;

    assign pop          = result_valid && !result_stall;
    assign result_valid = (count_reg != '0);
    assign head         = mem[rd_ptr_reg];
    assign room         = (count_reg <= u8d_pkg::FIFO_CNT_W'(u8d_pkg::FIFO_DEPTH - 2));
    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + u8d_pkg::FIFO_PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + u8d_pkg::FIFO_PTR_W'(pop);
        count_next  = count_reg + u8d_pkg::FIFO_CNT_W'(push.count)
                      - u8d_pkg::FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            mem[wr_ptr_plus1] <= push.second;
    end

`ifndef ASSERT_OFF
    a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != 2'd0) |->
            (({1'b0, count_reg} + {2'b00, push.count}) <= (u8d_pkg::FIFO_CNT_W + 1)'(
                u8d_pkg::FIFO_DEPTH)))
        else $error("Result queue overflow.");

    a_ptr_spacing : assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != u8d_pkg::FIFO_CNT_W'(u8d_pkg::FIFO_DEPTH)) |->
            ((wr_ptr_reg - rd_ptr_reg) == count_reg[u8d_pkg::FIFO_PTR_W-1:0]))
        else $error("Queue pointers disagree with the fill count.");

    a_head_held : assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(head)))
        else $error("Result word changed while stalled.");
`endif

endmodule
